FILE: rtl/core/pdse_pkg.sv
// Package for the probability-delta subexponential encoder: widths, defaults,
// stage payload types and constant functions for the bucket layout of the code.
// No dependencies.
package pdse_pkg;

   localparam int unsigned SPLIT_MODULUS_DEF = 13;
   localparam int unsigned SUBEXP_K_DEF      = 4;
   localparam int unsigned ALPHABET          = 255;
   localparam int unsigned PROB_W            = 8;
   localparam int unsigned IDX_W             = 8;
   localparam int unsigned CODE_W            = 11;
   localparam int unsigned LEN_W             = 4;
   localparam int unsigned ACC_W             = 16;
   localparam int unsigned MAX_BUCKETS       = 8;
   localparam int unsigned RECIP_SHIFT       = 16;

   typedef struct packed {
      logic             invalid;
      logic [IDX_W-1:0] idx;
   } pdse_index_type;

   typedef struct packed {
      logic             invalid;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] quot;
   } pdse_quot_type;

   typedef struct packed {
      logic              invalid;
      logic [IDX_W-1:0]  idx;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
   } pdse_result_type;

   function automatic int unsigned bucket_bits(int unsigned i, int unsigned k);
      int unsigned b;
      b = (i != 0) ? k + i - 1 : k;
      if (b > 20) b = 20;
      return b;
   endfunction

   function automatic int unsigned bucket_base(int unsigned i, int unsigned k);
      int unsigned mk;
      mk = 0;
      for (int unsigned j = 0; j < 32; j++) begin
         if (j < i) mk += (1 << bucket_bits(j, k));
      end
      return mk;
   endfunction

   function automatic int unsigned term_bucket(int unsigned k);
      int unsigned t;
      logic        done;
      t    = 0;
      done = 1'b0;
      for (int unsigned s = 0; s < 32; s++) begin
         if (!done) begin
            if (ALPHABET <= bucket_base(s, k) + 3 * (1 << bucket_bits(s, k))) begin
               t    = s;
               done = 1'b1;
            end
         end
      end
      return t;
   endfunction

   function automatic int unsigned bit_count(int unsigned n);
      int unsigned l;
      l = 0;
      for (int unsigned s = 0; s < 32; s++) begin
         if ((n >> s) != 0) l = s + 1;
      end
      return l;
   endfunction

endpackage

FILE: rtl/core/pdse_remap.sv
// First stage: recentres the new probability around the old one, mirrored
// for an old value in the upper half. Depends on pdse_pkg.
module pdse_remap (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic [pdse_pkg::PROB_W-1:0]  new_prob,
   input  logic [pdse_pkg::PROB_W-1:0]  old_prob,
   output logic                         out_valid,
   input  logic                         out_stall,
   output pdse_pkg::pdse_index_type     out_data
);

   localparam logic [pdse_pkg::PROB_W-1:0] TOP_VAL = pdse_pkg::PROB_W'(pdse_pkg::ALPHABET - 1);

   logic                         valid_ff;
   logic                         valid_in;
   pdse_pkg::pdse_index_type     data_ff;
   pdse_pkg::pdse_index_type     data_in;
   logic [pdse_pkg::PROB_W-1:0]  v_fix;
   logic [pdse_pkg::PROB_W-1:0]  m_fix;
   logic [pdse_pkg::PROB_W-1:0]  v_z;
   logic [pdse_pkg::PROB_W-1:0]  m_z;
   logic [pdse_pkg::PROB_W-1:0]  x_val;
   logic [pdse_pkg::PROB_W-1:0]  y_val;
   logic [pdse_pkg::PROB_W:0]    rc_val;
   logic                         upper;

   assign in_stall = valid_ff && out_stall;

   always_comb begin
      v_fix = (new_prob == '0) ? pdse_pkg::PROB_W'(1) : new_prob;
      m_fix = (old_prob == '0) ? pdse_pkg::PROB_W'(1) : old_prob;
      v_z   = v_fix - pdse_pkg::PROB_W'(1);
      m_z   = m_fix - pdse_pkg::PROB_W'(1);
      upper = ({m_z, 1'b0} > (pdse_pkg::PROB_W + 1)'(pdse_pkg::ALPHABET));
      x_val = upper ? TOP_VAL - v_z : v_z;
      y_val = upper ? TOP_VAL - m_z : m_z;
      if ({1'b0, x_val} > {y_val, 1'b0}) begin
         rc_val = {1'b0, x_val};
      end else if (x_val >= y_val) begin
         rc_val = {x_val - y_val, 1'b0};
      end else begin
         rc_val = {y_val - x_val, 1'b0} - (pdse_pkg::PROB_W + 1)'(1);
      end
      data_in.invalid = (v_fix == m_fix);
      data_in.idx     = data_in.invalid ? '0
                                        : pdse_pkg::IDX_W'(rc_val - (pdse_pkg::PROB_W + 1)'(1));
      valid_in = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && !in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/core/pdse_split.sv
// Second and third stages: modulus split of the recentred index, a reciprocal
// multiply for the quotient, then correction and reordering. Depends on pdse_pkg.
module pdse_split #(
   parameter int unsigned SPLIT_MODULUS = pdse_pkg::SPLIT_MODULUS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  pdse_pkg::pdse_index_type in_data,
   output logic                     out_valid,
   input  logic                     out_stall,
   output pdse_pkg::pdse_index_type out_data
);

   localparam int unsigned HALF   = SPLIT_MODULUS / 2;
   localparam int unsigned NMAX   = pdse_pkg::ALPHABET - 1;
   localparam int unsigned TOP    = (NMAX >= 1 + HALF) ? (NMAX - 1 - HALF) / SPLIT_MODULUS + 1 : 1;
   localparam int unsigned RECIP  = (1 << pdse_pkg::RECIP_SHIFT) / SPLIT_MODULUS;
   localparam int unsigned PROD_W = pdse_pkg::IDX_W + pdse_pkg::RECIP_SHIFT;
   localparam int unsigned ARITH_W = 16;

   logic                          a_valid_ff;
   logic                          a_valid_in;
   pdse_pkg::pdse_quot_type       a_data_ff;
   pdse_pkg::pdse_quot_type       a_data_in;
   logic                          a_stall;
   logic                          b_valid_ff;
   logic                          b_valid_in;
   pdse_pkg::pdse_index_type      b_data_ff;
   pdse_pkg::pdse_index_type      b_data_in;
   logic [PROD_W-1:0]             prod;
   logic [ARITH_W-1:0]            qm;
   logic [ARITH_W-1:0]            rem0;
   logic [ARITH_W-1:0]            rem;
   logic [ARITH_W-1:0]            quot;
   logic [ARITH_W-1:0]            reord;

   assign a_stall  = b_valid_ff && out_stall;
   assign in_stall = a_valid_ff && a_stall;

   always_comb begin
      prod              = PROD_W'(in_data.idx) * PROD_W'(RECIP);
      a_data_in.invalid = in_data.invalid;
      a_data_in.idx     = in_data.idx;
      a_data_in.quot    = prod[PROD_W-1 -: pdse_pkg::IDX_W];
      a_valid_in        = in_stall ? a_valid_ff : in_valid;
   end

   always_comb begin
      qm   = ARITH_W'(a_data_ff.quot) * ARITH_W'(SPLIT_MODULUS);
      rem0 = ARITH_W'(a_data_ff.idx) - qm;
      if (rem0 >= ARITH_W'(SPLIT_MODULUS)) begin
         quot = ARITH_W'(a_data_ff.quot) + ARITH_W'(1);
         rem  = rem0 - ARITH_W'(SPLIT_MODULUS);
      end else begin
         quot = ARITH_W'(a_data_ff.quot);
         rem  = rem0;
      end
      if (rem == ARITH_W'(HALF)) begin
         reord = quot;
      end else if (rem >= ARITH_W'(HALF)) begin
         reord = ARITH_W'(TOP) + ARITH_W'(a_data_ff.idx) - quot - ARITH_W'(1);
      end else begin
         reord = ARITH_W'(TOP) + ARITH_W'(a_data_ff.idx) - quot;
      end
      b_data_in.invalid = a_data_ff.invalid;
      b_data_in.idx     = a_data_ff.invalid ? '0 : pdse_pkg::IDX_W'(reord);
      b_valid_in        = a_stall ? b_valid_ff : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      if (in_valid && !in_stall) begin
         a_data_ff <= a_data_in;
      end
      if (a_valid_ff && !a_stall) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

FILE: rtl/core/pdse_code.sv
// Last stage: terminated subexponential code of the reordered index with a
// truncated-uniform tail, held in the output register. Depends on pdse_pkg.
module pdse_code #(
   parameter int unsigned SUBEXP_K = pdse_pkg::SUBEXP_K_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  pdse_pkg::pdse_index_type  in_data,
   output logic                      out_valid,
   input  logic                      out_stall,
   output pdse_pkg::pdse_result_type out_data
);

   localparam int unsigned ACC_W  = pdse_pkg::ACC_W;
   localparam int unsigned CNT_W  = 5;
   localparam int unsigned TERM   = pdse_pkg::term_bucket(SUBEXP_K);
   localparam int unsigned U_BASE = pdse_pkg::bucket_base(TERM, SUBEXP_K);
   localparam int unsigned U_N    = pdse_pkg::ALPHABET - U_BASE;
   localparam int unsigned U_L    = pdse_pkg::bit_count(U_N);
   localparam int unsigned U_M    = (1 << U_L) - U_N;
   localparam int unsigned U_SH   = (U_L > 0) ? U_L - 1 : 0;
   localparam int unsigned ONES_T = (1 << TERM) - 1;

   logic                      valid_ff;
   logic                      valid_in;
   pdse_pkg::pdse_result_type data_ff;
   pdse_pkg::pdse_result_type data_in;
   logic                      found;
   logic [ACC_W-1:0]          acc;
   logic [CNT_W-1:0]          len;
   logic [ACC_W-1:0]          word;
   logic [ACC_W-1:0]          u_val;
   logic [ACC_W-1:0]          u_diff;
   logic [ACC_W-1:0]          u_x;

   assign in_stall = valid_ff && out_stall;

   always_comb begin
      found  = 1'b0;
      acc    = '0;
      len    = '0;
      word   = ACC_W'(in_data.idx);
      u_val  = word - ACC_W'(U_BASE);
      u_diff = u_val - ACC_W'(U_M);
      u_x    = ACC_W'(U_M) + (u_diff >> 1);
      for (int unsigned i = 0; i < pdse_pkg::MAX_BUCKETS; i++) begin
         if (i < TERM && !found &&
             word < ACC_W'(pdse_pkg::bucket_base(i, SUBEXP_K) +
                           (1 << pdse_pkg::bucket_bits(i, SUBEXP_K)))) begin
            found = 1'b1;
            acc   = ACC_W'(((1 << i) - 1) << (pdse_pkg::bucket_bits(i, SUBEXP_K) + 1)) |
                    (word - ACC_W'(pdse_pkg::bucket_base(i, SUBEXP_K)));
            len   = CNT_W'(i + 1 + pdse_pkg::bucket_bits(i, SUBEXP_K));
         end
      end
      if (!found) begin
         if (U_L == 0) begin
            acc = ACC_W'(ONES_T);
            len = CNT_W'(TERM);
         end else if (u_val < ACC_W'(U_M)) begin
            acc = ACC_W'(ONES_T << U_SH) | u_val;
            len = CNT_W'(TERM + U_SH);
         end else begin
            acc = ((ACC_W'(ONES_T << U_SH) | u_x) << 1) | ACC_W'(u_diff[0]);
            len = CNT_W'(TERM + U_SH + 1);
         end
      end
      data_in.invalid     = in_data.invalid;
      data_in.idx         = in_data.idx;
      data_in.code_bits   = in_data.invalid ? '0 : acc[pdse_pkg::CODE_W-1:0];
      if (in_data.invalid) begin
         data_in.code_length = '0;
      end else if (len > CNT_W'(15)) begin
         data_in.code_length = '1;
      end else begin
         data_in.code_length = len[pdse_pkg::LEN_W-1:0];
      end
      valid_in = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && !in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/core/prob_delta_subexp_encoder.sv
// Probability-delta subexponential encoder, top level. Uses pdse_pkg, pdse_remap,
// pdse_split and pdse_code.
// Pipeline: four register stages in order: remap, split quotient, split reorder, code.
// Throughput: one transfer per cycle; each stage holds while the one after it stalls.
// Reset: synchronous, clears every stage valid bit; payload registers are not reset.
module prob_delta_subexp_encoder #(
   parameter int unsigned SPLIT_MODULUS = pdse_pkg::SPLIT_MODULUS_DEF,
   parameter int unsigned SUBEXP_K      = pdse_pkg::SUBEXP_K_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pdse_pkg::PROB_W-1:0]  req_new_prob,
   input  logic [pdse_pkg::PROB_W-1:0]  req_old_prob,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pdse_pkg::CODE_W-1:0]  rsp_code_bits,
   output logic [pdse_pkg::LEN_W-1:0]   rsp_code_length,
   output logic [pdse_pkg::IDX_W-1:0]   rsp_remapped_index,
   output logic                         rsp_invalid
);

   logic                      remap_valid;
   logic                      remap_stall;
   pdse_pkg::pdse_index_type  remap_data;
   logic                      split_valid;
   logic                      split_stall;
   pdse_pkg::pdse_index_type  split_data;
   pdse_pkg::pdse_result_type result;

   pdse_remap u_remap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .new_prob  (req_new_prob),
      .old_prob  (req_old_prob),
      .out_valid (remap_valid),
      .out_stall (remap_stall),
      .out_data  (remap_data)
   );

   pdse_split #(
      .SPLIT_MODULUS (SPLIT_MODULUS)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (remap_valid),
      .in_stall  (remap_stall),
      .in_data   (remap_data),
      .out_valid (split_valid),
      .out_stall (split_stall),
      .out_data  (split_data)
   );

   pdse_code #(
      .SUBEXP_K (SUBEXP_K)
   ) u_code (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_stall  (split_stall),
      .in_data   (split_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (result)
   );

   assign rsp_code_bits      = result.code_bits;
   assign rsp_code_length    = result.code_length;
   assign rsp_remapped_index = result.idx;
   assign rsp_invalid        = result.invalid;

   a_invalid_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |->
         rsp_code_length == '0 && rsp_code_bits == '0 && rsp_remapped_index == '0)
      else $error("invalid transfer carries a code");

   a_valid_has_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid |-> rsp_code_length != '0)
      else $error("empty code on a valid delta");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_remapped_index <= pdse_pkg::IDX_W'(pdse_pkg::ALPHABET - 2))
      else $error("remapped index out of range");

   a_bits_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_length < pdse_pkg::LEN_W'(pdse_pkg::CODE_W) |->
         (rsp_code_bits >> rsp_code_length) == '0)
      else $error("code bits above code length");

   a_stall_chain: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with output free");

endmodule
